// ===== design/rrp_pkg.sv =====
// rrp_pkg: shared sizes, mode codes and transfer payload types for the
// round-robin ready picker. No dependencies.
`default_nettype none

package rrp_pkg;

    localparam int SLOTS  = 64;
    localparam int CPUS   = 8;

    localparam int MODE_W = 3;
    localparam int CPU_W  = 3;
    localparam int SLOT_W = 6;

    // index width into the per-cpu pointer array
    localparam int CPU_IW = (CPUS > 1) ? $clog2(CPUS) : 1;

    localparam logic [MODE_W-1:0] MODE_SET_READY  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLR_READY  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET_IDLE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLR_IDLE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLAIM      = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CPU_W-1:0]  cpu;
        logic [SLOT_W-1:0] slot;
        logic              skip_valid;
        logic [SLOT_W-1:0] skip_slot;
    } t_in_item;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] granted_slot;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/rrp_pick.sv =====
// rrp_pick: rotating priority encoder over the eligible-slot mask.
// Depends on rrp_pkg for SLOTS and SLOT_W.
`default_nettype none

module rrp_pick (
    input  wire logic [rrp_pkg::SLOTS-1:0]  i_elig,
    input  wire logic [rrp_pkg::SLOT_W-1:0] i_start,
    output logic                            o_hit,
    output logic [rrp_pkg::SLOT_W-1:0]      o_slot
);

    logic [rrp_pkg::SLOTS-1:0] geq_mask;
    logic [rrp_pkg::SLOTS-1:0] upper;
    logic [rrp_pkg::SLOTS-1:0] cand;
    logic [rrp_pkg::SLOTS-1:0] lowest;

    always_comb begin
        for (int i = 0; i < rrp_pkg::SLOTS; i++) begin
            geq_mask[i] = (rrp_pkg::SLOT_W'(i) >= i_start);
        end
        upper  = i_elig & geq_mask;
        // wrap to the bottom when nothing at or above the start position
        cand   = (|upper) ? upper : i_elig;
        lowest = cand & (~cand + rrp_pkg::SLOTS'(1));
        o_hit  = |i_elig;
        o_slot = '0;
        for (int i = 0; i < rrp_pkg::SLOTS; i++) begin
            if (lowest[i]) begin
                o_slot = o_slot | rrp_pkg::SLOT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/round_robin_ready_picker.sv =====
// round_robin_ready_picker: top level with input register, ready/idle masks,
// per-cpu pointers and result register. Depends on rrp_pkg and rrp_pick.
`default_nettype none

// Per-CPU round-robin picker over a ready bitmap of task slots. One request is
// taken per cycle while not stalled; each produces exactly one result after its
// transfer in (input register, then a single pass through the mask update and
// rotating priority encoder into the result register). Mask updates (set/clear
// ready, set/clear idle mark) return granted=0, slot=0. Peek and claim search
// from the slot after the CPU's last grant, wrapping, skipping idle-marked,
// not-ready and the optional skip slot; a hit moves that CPU's pointer, and a
// claim also clears the ready bit. Back-to-back requests see each other's
// updates in order. Stall on the result side holds the result and backs up
// through the input register.
module round_robin_ready_picker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire rrp_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output rrp_pkg::t_out_item     o_out_item
);

    localparam int CPU_XW = (rrp_pkg::CPU_IW > rrp_pkg::CPU_W) ?
                            rrp_pkg::CPU_IW : rrp_pkg::CPU_W;

    logic                          r_in_valid;
    rrp_pkg::t_in_item             r_in;
    logic                          r_out_valid;
    rrp_pkg::t_out_item            r_out;
    logic [rrp_pkg::SLOTS-1:0]     r_ready;
    logic [rrp_pkg::SLOTS-1:0]     r_idle;
    logic [rrp_pkg::SLOT_W-1:0]    r_last [rrp_pkg::CPUS];

    logic [rrp_pkg::SLOTS-1:0]     n_ready;
    logic [rrp_pkg::SLOTS-1:0]     n_idle;
    rrp_pkg::t_out_item            n_out;
    logic                          n_ptr_we;

    logic                          out_can_load;
    logic                          fire;
    logic [CPU_XW-1:0]             cpu_x;
    logic [rrp_pkg::CPU_IW-1:0]    cpu_idx;
    logic                          cpu_ok;
    logic [rrp_pkg::SLOTS-1:0]     slot_dec;
    logic [rrp_pkg::SLOTS-1:0]     skip_dec;
    logic [rrp_pkg::SLOTS-1:0]     elig;
    logic [rrp_pkg::SLOT_W-1:0]    ptr;
    logic [rrp_pkg::SLOT_W-1:0]    start;
    logic                          pick_hit;
    logic [rrp_pkg::SLOT_W-1:0]    pick_slot;

    assign out_can_load = !r_out_valid || !i_out_stall;
    assign fire         = r_in_valid && out_can_load;
    assign o_in_stall   = r_in_valid && !out_can_load;
    assign o_out_valid  = r_out_valid;
    assign o_out_item   = r_out;

    assign cpu_x   = CPU_XW'(r_in.cpu);
    assign cpu_idx = cpu_x[rrp_pkg::CPU_IW-1:0];
    assign cpu_ok  = (32'(r_in.cpu) < 32'(rrp_pkg::CPUS));
    assign ptr     = r_last[cpu_idx];
    assign start   = (ptr == rrp_pkg::SLOT_W'(rrp_pkg::SLOTS - 1)) ?
                     '0 : ptr + rrp_pkg::SLOT_W'(1);

    // slots at or beyond SLOTS decode to nothing
    always_comb begin
        for (int i = 0; i < rrp_pkg::SLOTS; i++) begin
            slot_dec[i] = (r_in.slot == rrp_pkg::SLOT_W'(i));
            skip_dec[i] = r_in.skip_valid && (r_in.skip_slot == rrp_pkg::SLOT_W'(i));
        end
        elig = r_ready & ~r_idle & ~skip_dec;
    end

    rrp_pick u_pick (
        .i_elig  (elig),
        .i_start (start),
        .o_hit   (pick_hit),
        .o_slot  (pick_slot)
    );

    always_comb begin
        n_ready  = r_ready;
        n_idle   = r_idle;
        n_ptr_we = 1'b0;
        n_out    = '0;
        unique case (r_in.mode) inside
            rrp_pkg::MODE_SET_READY: n_ready = r_ready | slot_dec;
            rrp_pkg::MODE_CLR_READY: n_ready = r_ready & ~slot_dec;
            rrp_pkg::MODE_SET_IDLE:  n_idle  = r_idle | slot_dec;
            rrp_pkg::MODE_CLR_IDLE:  n_idle  = r_idle & ~slot_dec;
            rrp_pkg::MODE_PEEK, rrp_pkg::MODE_CLAIM: begin
                if (cpu_ok && pick_hit) begin
                    n_ptr_we           = 1'b1;
                    n_out.granted      = 1'b1;
                    n_out.granted_slot = pick_slot;
                    if (r_in.mode == rrp_pkg::MODE_CLAIM) begin
                        for (int i = 0; i < rrp_pkg::SLOTS; i++) begin
                            if (pick_slot == rrp_pkg::SLOT_W'(i)) begin
                                n_ready[i] = 1'b0;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ready     <= '0;
            r_idle      <= '0;
            for (int c = 0; c < rrp_pkg::CPUS; c++) begin
                r_last[c] <= '0;
            end
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_can_load) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_ready <= n_ready;
                r_idle  <= n_idle;
                if (n_ptr_we) begin
                    r_last[cpu_idx] <= pick_slot;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_round_robin_ready_picker.sv =====
`timescale 1ns / 1ps
// tb_round_robin_ready_picker: self-checking bench for the round-robin ready picker,
// with a queue-fed request driver, a result monitor and a grant predictor.
// Depends on rrp_pkg and round_robin_ready_picker.

module tb_round_robin_ready_picker;

    import rrp_pkg::*;

    localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;

    localparam int RANDOM_REQUESTS = 1450;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;

    logic      i_clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // predictor state
    logic [SLOTS-1:0]  ready_mask;
    logic [SLOTS-1:0]  idle_mask;
    logic [SLOT_W-1:0] last_grant [CPUS];

    t_in_item  request_queue   [$];
    t_out_item expected_grants [$];

    int request_total  = 0;
    int sent_count     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    logic steady       = 1'b0;

    round_robin_ready_picker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_in_item make_request(logic [MODE_W-1:0] mode, int cpu, int slot,
                                              logic skip_valid, int skip_slot);
        t_in_item req;
        req.mode       = mode;
        req.cpu        = CPU_W'(cpu);
        req.slot       = SLOT_W'(slot);
        req.skip_valid = skip_valid;
        req.skip_slot  = SLOT_W'(skip_slot);
        return req;
    endfunction

    // applies one request to the predictor state and returns the expected result
    function automatic t_out_item apply_request(t_in_item req);
        t_out_item        res;
        logic [SLOTS-1:0] eligible;
        int               idx;
        int               start;
        int               s;
        res = '0;
        idx = int'(req.slot);
        case (req.mode) inside
            MODE_SET_READY: if (idx < SLOTS) ready_mask[idx] = 1'b1;
            MODE_CLR_READY: if (idx < SLOTS) ready_mask[idx] = 1'b0;
            MODE_SET_IDLE:  if (idx < SLOTS) idle_mask[idx] = 1'b1;
            MODE_CLR_IDLE:  if (idx < SLOTS) idle_mask[idx] = 1'b0;
            MODE_PEEK, MODE_CLAIM: begin
                if (int'(req.cpu) < CPUS) begin
                    eligible = ready_mask & ~idle_mask;
                    if (req.skip_valid && int'(req.skip_slot) < SLOTS)
                        eligible[req.skip_slot] = 1'b0;
                    start = (int'(last_grant[req.cpu]) + 1) % SLOTS;
                    for (int i = 0; i < SLOTS; i++) begin
                        s = (start + i) % SLOTS;
                        if (eligible[s] && !res.granted) begin
                            res.granted      = 1'b1;
                            res.granted_slot = SLOT_W'(s);
                        end
                    end
                    if (res.granted) begin
                        last_grant[req.cpu] = res.granted_slot;
                        if (req.mode == MODE_CLAIM)
                            ready_mask[res.granted_slot] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        steady      <= (cycle_count >= 1100) && (cycle_count < 1700);
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // request driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_grants.push_back(apply_request(in_item));
                sent_count++;
            end
            if (!in_valid || !o_in_stall) begin
                if (request_queue.size() > 0 && (steady || $urandom_range(99) >= 34)) begin
                    in_valid <= 1'b1;
                    in_item  <= request_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_grants.size() == 0) begin
                    mismatch_count++;
                    $error("result transfer with no request outstanding");
                end else begin
                    want = expected_grants.pop_front();
                    if (o_out_item.granted !== want.granted) begin
                        mismatch_count++;
                        $error("granted: expected %0d, actual %0d",
                               want.granted, o_out_item.granted);
                    end
                    if (o_out_item.granted_slot !== want.granted_slot) begin
                        mismatch_count++;
                        $error("granted_slot: expected %0d, actual %0d",
                               want.granted_slot, o_out_item.granted_slot);
                    end
                end
            end
            out_stall <= !steady && ($urandom_range(99) < 34);
        end
    end

    initial begin
        int               pick;
        logic [MODE_W-1:0] mode;
        int               slot;
        int               skip_slot;

        ready_mask = '0;
        idle_mask  = '0;
        for (int c = 0; c < CPUS; c++)
            last_grant[c] = '0;

        // directed: empty search, extremes, wrap, skip, idle marks, unused modes
        request_queue.push_back(make_request(MODE_PEEK,      0,  0, 1'b0,  0));
        request_queue.push_back(make_request(MODE_CLAIM,     7, 63, 1'b1, 63));
        request_queue.push_back(make_request(MODE_SET_READY, 0, 63, 1'b0,  0));
        request_queue.push_back(make_request(MODE_SET_READY, 7,  0, 1'b1, 63));
        request_queue.push_back(make_request(MODE_SET_READY, 0, 42, 1'b0,  0));
        request_queue.push_back(make_request(MODE_SET_READY, 0, 21, 1'b0,  0));
        request_queue.push_back(make_request(MODE_RSVD_6,    5, 63, 1'b1, 63));
        request_queue.push_back(make_request(MODE_RSVD_7,    2, 21, 1'b0, 21));
        request_queue.push_back(make_request(MODE_PEEK,      0,  0, 1'b1, 21));
        request_queue.push_back(make_request(MODE_CLAIM,     0,  0, 1'b0,  0));
        request_queue.push_back(make_request(MODE_CLAIM,     0,  0, 1'b1,  0));
        request_queue.push_back(make_request(MODE_SET_IDLE,  0, 21, 1'b0,  0));
        request_queue.push_back(make_request(MODE_PEEK,      7,  0, 1'b1, 42));
        request_queue.push_back(make_request(MODE_CLR_IDLE,  0, 21, 1'b0,  0));
        request_queue.push_back(make_request(MODE_CLAIM,     7,  0, 1'b0, 42));
        request_queue.push_back(make_request(MODE_SET_IDLE,  3, 42, 1'b0,  0));
        request_queue.push_back(make_request(MODE_CLAIM,     3,  0, 1'b0,  0));
        request_queue.push_back(make_request(MODE_CLR_READY, 0, 42, 1'b0,  0));
        request_queue.push_back(make_request(MODE_CLR_IDLE,  0, 42, 1'b0,  0));
        request_queue.push_back(make_request(MODE_SET_READY, 0, 63, 1'b0,  0));
        request_queue.push_back(make_request(MODE_SET_READY, 0, 62, 1'b0,  0));
        request_queue.push_back(make_request(MODE_CLAIM,     5,  0, 1'b1, 62));
        request_queue.push_back(make_request(MODE_CLAIM,     5,  0, 1'b1, 63));
        request_queue.push_back(make_request(MODE_CLR_READY, 0,  0, 1'b0,  0));

        // random: mostly ready updates and searches, a few reserved modes
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(99);
            if (pick < 30)      mode = MODE_SET_READY;
            else if (pick < 38) mode = MODE_CLR_READY;
            else if (pick < 46) mode = MODE_SET_IDLE;
            else if (pick < 56) mode = MODE_CLR_IDLE;
            else if (pick < 74) mode = MODE_PEEK;
            else if (pick < 97) mode = MODE_CLAIM;
            else if (pick < 99) mode = MODE_RSVD_6;
            else                mode = MODE_RSVD_7;
            // bias some traffic onto a few slots so skips and idle marks collide
            slot      = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(63);
            skip_slot = ($urandom_range(1) == 0) ? $urandom_range(7) : $urandom_range(63);
            request_queue.push_back(make_request(mode, $urandom_range(7), slot,
                                                 1'($urandom_range(1)), skip_slot));
        end
        request_total = request_queue.size();

        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;

        while (sent_count < request_total)
            @(posedge i_clk);
        while (expected_grants.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
